// ----- src/linear_blend_skinning_vertex_defines.svh -----
// ----------------------------------------------------------------------------
// Skinning block assertion macros
// Implication checks on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef LINEAR_BLEND_SKINNING_VERTEX_DEFINES_SVH
`define LINEAR_BLEND_SKINNING_VERTEX_DEFINES_SVH

// same-cycle implication
`define LBS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/lbs_pkg.sv -----
// ----------------------------------------------------------------------------
// lbs_pkg
// Shared constants, types and helpers of the skinning block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package lbs_pkg;

  localparam int JOINTS  = 64;
  localparam int JOINT_W = 6;
  localparam int ELEM_W  = 4;
  localparam int ADDR_W  = $clog2(JOINTS * 16);
  localparam int DATA_W  = 32;
  localparam int WGT_W   = 16;
  localparam int OPD_W   = 33;
  localparam int PROD_W  = 2 * OPD_W;
  localparam int ACC_W   = 52;

  localparam logic [DATA_W-1:0] ONE_Q16 = 32'h0001_0000;

  typedef enum logic [1:0] {
    MODE_INV  = 2'd0,
    MODE_POSE = 2'd1,
    MODE_SKIN = 2'd2
  } mode_e;

  typedef struct packed {
    logic             mul_en;
    logic             acc_en;
    logic             clr;
    logic             dst;
    logic             sh15;
    logic [OPD_W-1:0] a;
    logic [OPD_W-1:0] b;
  } mac_op_t;

  function automatic logic [DATA_W-1:0] sat32(input logic [ACC_W-1:0] x);
    logic [ACC_W-DATA_W:0] hi;
    hi = x[ACC_W-1:DATA_W-1];
    if ((&hi) || !(|hi)) begin
      return x[DATA_W-1:0];
    end
    return x[ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
  endfunction

endpackage
`default_nettype wire

// ----- src/linear_blend_skinning_vertex.sv -----
// ----------------------------------------------------------------------------
// linear_blend_skinning_vertex
// Four-influence linear blend skinning of one vertex, Q16.16 fixed point.
// ----------------------------------------------------------------------------
//  channel  dir  tuser          tdata
//  s_axis   in   mode[1:0]      joint, element, value, pos, nrm, joints, wgts
//  m_axis   out  -              out_pos_x .. out_nrm_z
//
//  Load request: taken without leaving the idle state, memory written at accept.
//  Skin request: 344 MAC ops on the one multiplier; not ready until result taken.
//  No clearing pass: palette entries must be written before use.
//  Reset clears the sequencer and the MAC's accumulator-valid flag only.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "linear_blend_skinning_vertex_defines.svh"
module linear_blend_skinning_vertex (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // [1:0] mode
  input  wire logic [1:0]   s_axis_tuser,
  // joint_index, element_index, element_value, pos_x, pos_y, pos_z,
  // nrm_x, nrm_y, nrm_z, influence_joints, influence_weights, zero pad
  input  wire logic [327:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // out_pos_x, out_pos_y, out_pos_z, out_nrm_x, out_nrm_y, out_nrm_z
  output logic [191:0]      m_axis_tdata
);

  localparam int AW = lbs_pkg::ADDR_W;
  localparam int DW = lbs_pkg::DATA_W;
  localparam int OW = lbs_pkg::OPD_W;

  typedef enum logic [1:0] {ST_IDLE, ST_MAT, ST_VEC, ST_OUT} state_e;

  state_e      state_q;
  logic [3:0]  e_q;
  logic [1:0]  inf_q;
  logic [2:0]  k_q;
  logic [2:0]  o_q;
  logic [1:0]  t_q;
  logic [1:0]  ph_q;

  logic [DW-1:0] vec_q [6];
  logic [23:0]   ij_q;
  logic [63:0]   iw_q;
  logic [DW-1:0] s_q   [16];
  logic [DW-1:0] res_q [6];

  logic [lbs_pkg::JOINT_W-1:0] w_joint, jsel;
  logic [lbs_pkg::ELEM_W-1:0]  w_elem;
  logic [DW-1:0]               w_val;
  logic                        in_acc, w_ok, j_ok;
  logic [lbs_pkg::WGT_W-1:0]   wsel;
  logic [DW-1:0]               rd_inv, rd_pose, vsel;
  logic [AW-1:0]               raddr_inv, raddr_pose;
  logic [1:0]                  jcol;
  logic                        nrm;
  logic [2:0]                  vidx;
  lbs_pkg::mac_op_t            op;
  logic [lbs_pkg::ACC_W-1:0]   acc0, acc1;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign w_joint = s_axis_tdata[5:0];
  assign w_elem  = s_axis_tdata[9:6];
  assign w_val   = s_axis_tdata[41:10];
  assign w_ok    = 32'(w_joint) < lbs_pkg::JOINTS;

  assign jsel = ij_q[6*inf_q +: 6];
  assign wsel = iw_q[16*inf_q +: 16];
  assign j_ok = 32'(jsel) < lbs_pkg::JOINTS;

  assign raddr_inv  = AW'({jsel, e_q[3:2], k_q[1:0]});
  assign raddr_pose = AW'({jsel, k_q[1:0], e_q[1:0]});

  lbs_palette u_pal (
    .clk_i       (clk_i),
    .we_inv_i    (in_acc && s_axis_tuser == lbs_pkg::MODE_INV && w_ok),
    .we_pose_i   (in_acc && s_axis_tuser == lbs_pkg::MODE_POSE && w_ok),
    .waddr_i     (AW'({w_joint, w_elem})),
    .wdata_i     (w_val),
    .raddr_inv_i (raddr_inv),
    .raddr_pose_i(raddr_pose),
    .rdata_inv_o (rd_inv),
    .rdata_pose_o(rd_pose)
  );

  always_comb begin
    nrm  = o_q > 3'd2;
    jcol = nrm ? 2'(o_q - 3'd3) : o_q[1:0];
    vidx = nrm ? 3'(t_q) + 3'd3 : 3'(t_q);
    if (t_q == 2'd3) begin
      vsel = nrm ? '0 : lbs_pkg::ONE_Q16;
    end else begin
      vsel = vec_q[vidx];
    end

    op        = '0;
    op.mul_en = (state_q == ST_MAT || state_q == ST_VEC) && ph_q == 2'd1;
    op.acc_en = (state_q == ST_MAT || state_q == ST_VEC) && ph_q == 2'd2;
    if (state_q == ST_MAT) begin
      if (k_q == 3'd4) begin
        op.dst  = 1'b1;
        op.clr  = inf_q == 2'd0;
        op.sh15 = 1'b1;
        op.a    = OW'($signed(lbs_pkg::sat32(acc0)));
        op.b    = OW'(wsel);
      end else begin
        op.clr  = k_q == 3'd0;
        op.a    = j_ok ? OW'($signed(rd_inv)) : '0;
        op.b    = OW'($signed(rd_pose));
      end
    end else begin
      op.clr = t_q == 2'd0;
      op.a   = OW'($signed(vsel));
      op.b   = OW'($signed(s_q[{t_q, jcol}]));
    end
  end

  lbs_mac u_mac (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .op_i  (op),
    .acc0_o(acc0),
    .acc1_o(acc1)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      e_q     <= '0;
      inf_q   <= '0;
      k_q     <= '0;
      o_q     <= '0;
      t_q     <= '0;
      ph_q    <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_acc && s_axis_tuser == lbs_pkg::MODE_SKIN) begin
            state_q <= ST_MAT;
            e_q     <= '0;
            inf_q   <= '0;
            k_q     <= '0;
            ph_q    <= '0;
          end
        end
        ST_MAT: begin
          ph_q <= ph_q + 2'd1;
          if (ph_q == 2'd3) begin
            if (k_q == 3'd4) begin
              k_q <= '0;
              inf_q <= inf_q + 2'd1;
              if (inf_q == 2'd3) begin
                e_q <= e_q + 4'd1;
                if (e_q == 4'd15) begin
                  state_q <= ST_VEC;
                  o_q     <= '0;
                  t_q     <= '0;
                end
              end
            end else begin
              k_q <= k_q + 3'd1;
            end
          end
        end
        ST_VEC: begin
          ph_q <= ph_q + 2'd1;
          if (ph_q == 2'd3) begin
            t_q <= t_q + 2'd1;
            if (t_q == 2'd3) begin
              if (o_q == 3'd5) begin
                state_q <= ST_OUT;
              end else begin
                o_q <= o_q + 3'd1;
              end
            end
          end
        end
        ST_OUT: begin
          if (m_axis_tready) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && s_axis_tuser == lbs_pkg::MODE_SKIN) begin
      for (int i = 0; i < 6; i++) begin
        vec_q[i] <= s_axis_tdata[42 + 32*i +: 32];
      end
      ij_q <= s_axis_tdata[257:234];
      iw_q <= s_axis_tdata[321:258];
    end
    if (state_q == ST_MAT && ph_q == 2'd3 && k_q == 3'd4 && inf_q == 2'd3) begin
      s_q[e_q] <= lbs_pkg::sat32(acc1);
    end
    if (state_q == ST_VEC && ph_q == 2'd3 && t_q == 2'd3) begin
      res_q[o_q] <= lbs_pkg::sat32(acc0);
    end
  end

  assign s_axis_tready = state_q == ST_IDLE;
  assign m_axis_tvalid = state_q == ST_OUT;
  assign m_axis_tdata  = {res_q[5], res_q[4], res_q[3], res_q[2], res_q[1], res_q[0]};

  `LBS_ASSERT_NOW(a_out_blocks_in, m_axis_tvalid, !s_axis_tready, "input taken while result pending")
  `LBS_ASSERT_NEXT(a_skin_busy, in_acc && s_axis_tuser == lbs_pkg::MODE_SKIN, !s_axis_tready && !m_axis_tvalid, "skin request did not start work")
  `LBS_ASSERT_NEXT(a_load_ready, in_acc && s_axis_tuser != lbs_pkg::MODE_SKIN, s_axis_tready, "load request left block busy")

endmodule
`default_nettype wire

// ----- src/lbs_mac.sv -----
// ----------------------------------------------------------------------------
// lbs_mac
// Shared multiply, arithmetic shift and two-accumulator add unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lbs_mac (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire lbs_pkg::mac_op_t            op_i,
  output logic [lbs_pkg::ACC_W-1:0]        acc0_o,
  output logic [lbs_pkg::ACC_W-1:0]        acc1_o
);

  logic signed [lbs_pkg::OPD_W-1:0]  a_s, b_s;
  logic signed [lbs_pkg::PROD_W-1:0] prod_d, prod_q, shv;
  logic        [lbs_pkg::ACC_W-1:0]  base, sum;
  logic        [lbs_pkg::ACC_W-1:0]  acc0_q, acc1_q;
  logic                              acc_vld_q;

  always_comb begin
    a_s    = op_i.a;
    b_s    = op_i.b;
    prod_d = a_s * b_s;
    shv    = op_i.sh15 ? (prod_q >>> 15) : (prod_q >>> 16);
    if (op_i.clr) begin
      base = '0;
    end else begin
      base = op_i.dst ? acc1_q : acc0_q;
    end
    sum = base + shv[lbs_pkg::ACC_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (op_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (op_i.acc_en && !op_i.dst) begin
      acc0_q <= sum;
    end
    if (op_i.acc_en && op_i.dst) begin
      acc1_q <= sum;
    end
  end

  // tracks that an accumulator has been loaded since reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_vld_q <= 1'b0;
    end else if (op_i.acc_en) begin
      acc_vld_q <= 1'b1;
    end
  end

  assign acc0_o = acc_vld_q ? acc0_q : '0;
  assign acc1_o = acc_vld_q ? acc1_q : '0;

endmodule
`default_nettype wire

// ----- src/lbs_palette.sv -----
// ----------------------------------------------------------------------------
// lbs_palette
// Inverse bind and pose matrix memories, one write port, registered reads.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lbs_palette (
  input  wire logic                         clk_i,
  input  wire logic                         we_inv_i,
  input  wire logic                         we_pose_i,
  input  wire logic [lbs_pkg::ADDR_W-1:0]   waddr_i,
  input  wire logic [lbs_pkg::DATA_W-1:0]   wdata_i,
  input  wire logic [lbs_pkg::ADDR_W-1:0]   raddr_inv_i,
  input  wire logic [lbs_pkg::ADDR_W-1:0]   raddr_pose_i,
  output logic      [lbs_pkg::DATA_W-1:0]   rdata_inv_o,
  output logic      [lbs_pkg::DATA_W-1:0]   rdata_pose_o
);

  logic [lbs_pkg::DATA_W-1:0] inv_mem  [lbs_pkg::JOINTS*16];
  logic [lbs_pkg::DATA_W-1:0] pose_mem [lbs_pkg::JOINTS*16];

  always_ff @(posedge clk_i) begin
    if (we_inv_i) begin
      inv_mem[waddr_i] <= wdata_i;
    end
    rdata_inv_o <= inv_mem[raddr_inv_i];
  end

  always_ff @(posedge clk_i) begin
    if (we_pose_i) begin
      pose_mem[waddr_i] <= wdata_i;
    end
    rdata_pose_o <= pose_mem[raddr_pose_i];
  end

endmodule
`default_nettype wire
